// ===== sv/mbrtu_pkg.sv =====
`default_nettype none

package mbrtu_pkg;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [7:0] EXC_FLAG         = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;

  localparam logic [7:0] FC_RD_COILS      = 8'h01;
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
  localparam logic [7:0] FC_WRITE_HOLDING = 8'h06;

  localparam int MIN_FRAME = 5;

  localparam int RESP_IDX_W = 3;
  localparam logic [RESP_IDX_W-1:0] RESP_ADDR   = 3'd0;
  localparam logic [RESP_IDX_W-1:0] RESP_FUNC   = 3'd1;
  localparam logic [RESP_IDX_W-1:0] RESP_CODE   = 3'd2;
  localparam logic [RESP_IDX_W-1:0] RESP_CRC_LO = 3'd3;
  localparam logic [RESP_IDX_W-1:0] RESP_CRC_HI = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] station;
    logic [7:0] opcode;
  } resp_load_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mbrtu_resp_gen.sv =====
`default_nettype none

module mbrtu_resp_gen
  import mbrtu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire resp_load_t load,
  output logic            free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tx_item_t        out_data
);

  logic                  busy_r, busy_nxt;
  logic [RESP_IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]            sta_r, sta_nxt;
  logic [7:0]            opc_r, opc_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic                  xfer;
  logic [7:0]            cur_byte;

  assign xfer      = busy_r && out_ready;
  assign free      = !busy_r || (out_ready && (idx_r == RESP_CRC_HI));
  assign out_valid = busy_r;

  always_comb begin
    case (idx_r)
      RESP_ADDR:   cur_byte = sta_r;
      RESP_FUNC:   cur_byte = opc_r | EXC_FLAG;
      RESP_CODE:   cur_byte = EXC_ILLEGAL_FUNC;
      RESP_CRC_LO: cur_byte = crc_r[7:0];
      RESP_CRC_HI: cur_byte = crc_r[15:8];
      default:     cur_byte = 8'h00;
    endcase
    out_data.tx_byte = cur_byte;
    out_data.tx_last = (idx_r == RESP_CRC_HI);
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    sta_nxt  = sta_r;
    opc_nxt  = opc_r;
    crc_nxt  = crc_r;
    if (load.valid) begin
      busy_nxt = 1'b1;
      idx_nxt  = RESP_ADDR;
      sta_nxt  = load.station;
      opc_nxt  = load.opcode;
      crc_nxt  = CRC_PRESET;
    end else if (xfer) begin
      if (idx_r == RESP_CRC_HI) begin
        busy_nxt = 1'b0;
      end
      if (idx_r < RESP_CRC_LO) begin
        crc_nxt = crc_add(crc_r, cur_byte);
      end
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= RESP_ADDR;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    sta_r <= sta_nxt;
    opc_r <= opc_nxt;
    crc_r <= crc_nxt;
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid |-> free)
    else $error("Response loaded while the previous one is still pending.");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= RESP_CRC_HI))
    else $error("Response index out of range.");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid |=> (out_valid && (idx_r == RESP_ADDR)))
    else $error("Loaded response does not start with the address byte.");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !load.valid && (idx_r != RESP_CRC_HI)) |=>
      (busy_r && (idx_r == $past(idx_r) + 1'b1)))
    else $error("Response index did not advance after a transfer.");

endmodule

`default_nettype wire

// ===== sv/modbus_rtu_frame_checker.sv =====
// Modbus RTU request checker with exception responder.
// Input channel (in_valid/in_ready/in_data): one received byte per transfer,
// with frame_end set on the last byte of a frame. The CRC-16 over the frame,
// the address, the function code and the length are checked on that byte.
// A frame that fails a check, or that carries function code 1, 3, 5 or 6,
// is dropped without output. Otherwise a five-byte exception response
// (address, function | 0x80, 0x01, CRC low, CRC high) is sent on the output
// channel (out_valid/out_ready/out_data), tx_last marking its fifth byte.
// The first response byte is valid in the cycle after the frame's last byte
// is taken; one byte goes out per cycle while out_ready is high.
// Input bytes are taken one per cycle. A byte with frame_end set is held off
// only while a previous response still has bytes to send, so a stalled
// receiver blocks input at frame ends alone. The slave address is written
// through cfg_wr_en/cfg_wr_data only while the block is idle; the user must keep
// to this, as the block itself does not enforce it. Synchronous reset clears the
// frame state, drops any pending response and sets the slave address to 1.
`default_nettype none

module modbus_rtu_frame_checker
  import mbrtu_pkg::*;
#(
  parameter int MAX_FRAME = 256
)
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rx_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tx_item_t        out_data
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic [7:0]       slave_addr_r;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       held0_r, held0_nxt;
  logic [7:0]       held1_r, held1_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sta_r, sta_nxt;
  logic [7:0]       opc_r, opc_nxt;
  logic             ovl_r, ovl_nxt;

  logic             in_xfer;
  logic             resp_free;
  logic             frame_ok;
  logic [15:0]      rx_crc;
  resp_load_t       load;

  assign in_ready = !in_data.frame_end || resp_free;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    cnt_nxt   = cnt_r;
    sta_nxt   = sta_r;
    opc_nxt   = opc_r;
    ovl_nxt   = ovl_r;
    frame_ok  = 1'b0;
    rx_crc    = {in_data.rx_byte, held1_r};
    if (in_xfer) begin
      if (cnt_r >= CNT_W'(2)) begin
        crc_nxt = crc_add(crc_r, held0_r);
      end
      held0_nxt = held1_r;
      held1_nxt = in_data.rx_byte;
      if (cnt_r == '0) begin
        sta_nxt = in_data.rx_byte;
      end else if (cnt_r == CNT_W'(1)) begin
        opc_nxt = in_data.rx_byte;
      end
      if (cnt_r >= CNT_W'(MAX_FRAME)) begin
        ovl_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (in_data.frame_end) begin
        frame_ok = !ovl_nxt && (cnt_nxt >= CNT_W'(MIN_FRAME)) && (rx_crc == crc_nxt) &&
                   (sta_nxt == slave_addr_r) &&
                   !(opc_nxt inside {FC_RD_COILS, FC_READ_HOLDING,
                                     FC_WRITE_COIL, FC_WRITE_HOLDING});
        crc_nxt   = CRC_PRESET;
        held0_nxt = 8'h00;
        held1_nxt = 8'h00;
        cnt_nxt   = '0;
        sta_nxt   = 8'h00;
        opc_nxt   = 8'h00;
        ovl_nxt   = 1'b0;
      end
    end
    load.valid   = frame_ok;
    load.station = sta_r;
    load.opcode  = opc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'h01;
      crc_r        <= CRC_PRESET;
      held0_r      <= 8'h00;
      held1_r      <= 8'h00;
      cnt_r        <= '0;
      sta_r        <= 8'h00;
      opc_r        <= 8'h00;
      ovl_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slave_addr_r <= cfg_wr_data;
      end
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      cnt_r   <= cnt_nxt;
      sta_r   <= sta_nxt;
      opc_r   <= opc_nxt;
      ovl_r   <= ovl_nxt;
    end
  end

  mbrtu_resp_gen u_resp_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .free      (resp_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
